[design/assert_macros.svh]
// assertion macros used by complex_arithmetic_unit
// expects clk_i and rst_ni in the scope of use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// same-cycle implication
`define ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");
// next-cycle implication
`define ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_IMPL(lbl, ante, cons)
`define ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

[design/cau_pkg.sv]
// package for the complex arithmetic unit: op codes, status codes, widths
// no dependencies
`timescale 1ns / 1ps
package cau_pkg;
  localparam int DATA_W       = 16;
  localparam int FRAC_BITS_DEF = 8;
  // quotient bits: one above the result width catches the negative limit
  localparam int QW           = 17;

  typedef enum logic [1:0] {
    ACT_ADD = 2'd0,
    ACT_SUB = 2'd1,
    ACT_MUL = 2'd2,
    ACT_DIV = 2'd3
  } action_e;

  localparam logic [1:0] ST_OK  = 2'd0;
  localparam logic [1:0] ST_SAT = 2'd1;
  localparam logic [1:0] ST_DZ  = 2'd2;

  localparam logic [QW-1:0] Q_POS_MAX = 17'h07FFF;
  localparam logic [QW-1:0] Q_NEG_MAX = 17'h08000;
endpackage

[design/complex_arithmetic_unit.sv]
// complex add/sub/mul/div on signed fixed-point parts, fully pipelined
// stages: input register, products, sums, magnitudes and setup, divide, output
// one word per cycle unless stalled; restoring divide, one quotient bit per stage
// stages with no valid word accept new data even while the output is stalled
// reset (async, active low) clears only the valid bits; payload is not reset
// depends on cau_pkg and assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"
module complex_arithmetic_unit #(
  parameter int FRAC_BITS = cau_pkg::FRAC_BITS_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [1:0]                         action_i,
  input  logic signed [cau_pkg::DATA_W-1:0]  a_re_i,
  input  logic signed [cau_pkg::DATA_W-1:0]  a_im_i,
  input  logic signed [cau_pkg::DATA_W-1:0]  b_re_i,
  input  logic signed [cau_pkg::DATA_W-1:0]  b_im_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic signed [cau_pkg::DATA_W-1:0]  result_re_o,
  output logic signed [cau_pkg::DATA_W-1:0]  result_im_o,
  output logic [1:0]                         status_o
);
  import cau_pkg::*;

  localparam int PW   = 2 * DATA_W;       // product width
  localparam int SW   = PW + 1;           // sum of two products
  localparam int VW   = SW + 1;           // pre-clamp value
  localparam int DENW = PW;               // squared magnitude
  localparam int RW   = (PW + FRAC_BITS > DENW + QW) ? (PW + FRAC_BITS) : (DENW + QW);
  localparam int NST  = QW + 5;
  localparam int ST_OUT = NST - 1;

  typedef struct packed {
    logic [1:0]           op;
    logic                 dz;
    logic signed [VW-1:0] dir_re;
    logic signed [VW-1:0] dir_im;
    logic                 neg_re;
    logic                 neg_im;
    logic                 ovf_re;
    logic                 ovf_im;
    logic [DENW-1:0]      den;
    logic [RW-1:0]        rem_re;
    logic [RW-1:0]        rem_im;
    logic [QW-1:0]        q_re;
    logic [QW-1:0]        q_im;
  } pipe_t;

  // stage handshake: a stage advances when empty or when the next one advances
  logic [NST-1:0] v_q;
  logic [NST-1:0] adv;
  logic [NST-1:0] v_in;

  always_comb begin
    adv[ST_OUT] = !v_q[ST_OUT] || !out_stall_i;
    for (int k = ST_OUT - 1; k >= 0; k--) begin
      adv[k] = !v_q[k] || adv[k+1];
    end
  end

  assign v_in       = {v_q[NST-2:0], in_valid_i};
  assign in_stall_o = !adv[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      for (int k = 0; k < NST; k++) begin
        if (adv[k]) v_q[k] <= v_in[k];
      end
    end
  end

  // stage 1: input register
  logic [1:0]               op1_q;
  logic signed [DATA_W-1:0] ar1_q, ai1_q, br1_q, bi1_q;

  always_ff @(posedge clk_i) begin
    if (adv[0]) begin
      op1_q <= action_i;
      ar1_q <= a_re_i;
      ai1_q <= a_im_i;
      br1_q <= b_re_i;
      bi1_q <= b_im_i;
    end
  end

  // stage 2: six products, plus add/sub results
  logic [1:0]               op2_q;
  logic signed [PW-1:0]     p_rr_q, p_ii_q, p_ir_q, p_ri_q, p_bb_r_q, p_bb_i_q;
  logic signed [DATA_W:0]   as_re_q, as_im_q;

  always_ff @(posedge clk_i) begin
    if (adv[1]) begin
      op2_q    <= op1_q;
      p_rr_q   <= ar1_q * br1_q;
      p_ii_q   <= ai1_q * bi1_q;
      p_ir_q   <= ai1_q * br1_q;
      p_ri_q   <= ar1_q * bi1_q;
      p_bb_r_q <= br1_q * br1_q;
      p_bb_i_q <= bi1_q * bi1_q;
      if (op1_q == ACT_SUB) begin
        as_re_q <= {ar1_q[DATA_W-1], ar1_q} - {br1_q[DATA_W-1], br1_q};
        as_im_q <= {ai1_q[DATA_W-1], ai1_q} - {bi1_q[DATA_W-1], bi1_q};
      end else begin
        as_re_q <= {ar1_q[DATA_W-1], ar1_q} + {br1_q[DATA_W-1], br1_q};
        as_im_q <= {ai1_q[DATA_W-1], ai1_q} + {bi1_q[DATA_W-1], bi1_q};
      end
    end
  end

  // stage 3: sums of products
  logic [1:0]             op3_q;
  logic signed [SW-1:0]   s_re_q, s_im_q;
  logic [DENW-1:0]        den3_q;
  logic signed [DATA_W:0] as3_re_q, as3_im_q;

  always_ff @(posedge clk_i) begin
    if (adv[2]) begin
      op3_q    <= op2_q;
      as3_re_q <= as_re_q;
      as3_im_q <= as_im_q;
      den3_q   <= DENW'(p_bb_r_q) + DENW'(p_bb_i_q);
      if (op2_q == ACT_DIV) begin
        s_re_q <= {p_rr_q[PW-1], p_rr_q} + {p_ii_q[PW-1], p_ii_q};
        s_im_q <= {p_ir_q[PW-1], p_ir_q} - {p_ri_q[PW-1], p_ri_q};
      end else begin
        s_re_q <= {p_rr_q[PW-1], p_rr_q} - {p_ii_q[PW-1], p_ii_q};
        s_im_q <= {p_ir_q[PW-1], p_ir_q} + {p_ri_q[PW-1], p_ri_q};
      end
    end
  end

  // stage 4: magnitudes, scaled product, dividend setup and overflow pre-check
  pipe_t           p4_d, p4_q;
  logic [SW-1:0]   mag_re, mag_im;
  logic [SW-1:0]   shr_re, shr_im;
  logic [RW-1:0]   den_top;

  always_comb begin
    mag_re  = s_re_q[SW-1] ? SW'(-s_re_q) : SW'(s_re_q);
    mag_im  = s_im_q[SW-1] ? SW'(-s_im_q) : SW'(s_im_q);
    shr_re  = mag_re >> FRAC_BITS;
    shr_im  = mag_im >> FRAC_BITS;
    den_top = RW'(den3_q) << QW;
    p4_d        = '0;
    p4_d.op     = op3_q;
    p4_d.dz     = (den3_q == '0);
    p4_d.den    = den3_q;
    p4_d.neg_re = s_re_q[SW-1];
    p4_d.neg_im = s_im_q[SW-1];
    p4_d.rem_re = RW'(mag_re) << FRAC_BITS;
    p4_d.rem_im = RW'(mag_im) << FRAC_BITS;
    p4_d.ovf_re = (RW'(mag_re) << FRAC_BITS) >= den_top;
    p4_d.ovf_im = (RW'(mag_im) << FRAC_BITS) >= den_top;
    if (op3_q == ACT_MUL) begin
      p4_d.dir_re = s_re_q[SW-1] ? -$signed({1'b0, shr_re}) : $signed({1'b0, shr_re});
      p4_d.dir_im = s_im_q[SW-1] ? -$signed({1'b0, shr_im}) : $signed({1'b0, shr_im});
    end else begin
      p4_d.dir_re = VW'(as3_re_q);
      p4_d.dir_im = VW'(as3_im_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv[3]) p4_q <= p4_d;
  end

  // restoring divide, one quotient bit per stage on both parts
  pipe_t dq_q [QW];

  for (genvar j = 0; j < QW; j++) begin : g_div
    pipe_t         src;
    pipe_t         nxt;
    logic [RW-1:0] trial;

    if (j == 0) begin : g_first
      assign src = p4_q;
    end else begin : g_next
      assign src = dq_q[j-1];
    end

    always_comb begin
      trial = RW'(src.den) << (QW - 1 - j);
      nxt   = src;
      if (src.rem_re >= trial) begin
        nxt.rem_re        = src.rem_re - trial;
        nxt.q_re[QW-1-j]  = 1'b1;
      end
      if (src.rem_im >= trial) begin
        nxt.rem_im        = src.rem_im - trial;
        nxt.q_im[QW-1-j]  = 1'b1;
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv[4+j]) dq_q[j] <= nxt;
    end
  end

  // clamp a direct value, returns {sat, value}
  function automatic logic [DATA_W:0] clamp_dir(input logic signed [VW-1:0] v);
    logic [DATA_W:0] r;
    if (v > VW'(32'sd32767)) r = {1'b1, 16'h7FFF};
    else if (v < -VW'(32'sd32768)) r = {1'b1, 16'h8000};
    else r = {1'b0, v[DATA_W-1:0]};
    return r;
  endfunction

  // signed quotient with saturation, returns {sat, value}
  function automatic logic [DATA_W:0] clamp_div(input logic [QW-1:0] q, input logic neg,
                                                input logic ovf);
    logic [DATA_W:0] r;
    logic [QW-1:0]   nq;
    nq = -q;
    if (neg) begin
      if (ovf || q > Q_NEG_MAX) r = {1'b1, 16'h8000};
      else r = {1'b0, nq[DATA_W-1:0]};
    end else begin
      if (ovf || q > Q_POS_MAX) r = {1'b1, 16'h7FFF};
      else r = {1'b0, q[DATA_W-1:0]};
    end
    return r;
  endfunction

  // output stage
  pipe_t           fin;
  logic [DATA_W:0] c_re, c_im;
  logic [1:0]      st_d;
  logic signed [DATA_W-1:0] res_re_q, res_im_q;
  logic [1:0]      status_q;

  assign fin = dq_q[QW-1];

  always_comb begin
    if (fin.op == ACT_DIV) begin
      c_re = clamp_div(fin.q_re, fin.neg_re, fin.ovf_re);
      c_im = clamp_div(fin.q_im, fin.neg_im, fin.ovf_im);
    end else begin
      c_re = clamp_dir(fin.dir_re);
      c_im = clamp_dir(fin.dir_im);
    end
    st_d = (c_re[DATA_W] || c_im[DATA_W]) ? ST_SAT : ST_OK;
    if (fin.op == ACT_DIV && fin.dz) begin
      c_re = '0;
      c_im = '0;
      st_d = ST_DZ;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv[ST_OUT]) begin
      res_re_q <= c_re[DATA_W-1:0];
      res_im_q <= c_im[DATA_W-1:0];
      status_q <= st_d;
    end
  end

  assign out_valid_o = v_q[ST_OUT];
  assign result_re_o = res_re_q;
  assign result_im_o = res_im_q;
  assign status_o    = status_q;

  // checks
  `ASSERT_IMPL(a_stall_full, in_stall_o, out_valid_o && out_stall_i)
  `ASSERT_NEXT(a_take_word, in_valid_i && !in_stall_o, v_q[0])
  `ASSERT_IMPL(a_dz_zero, out_valid_o && status_o == ST_DZ,
               result_re_o == '0 && result_im_o == '0)
endmodule
